### rtl/lagged_rise_toggle_detector_defines.svh
// assertion macros for the lagged rise toggle detector checker
// needs a clock named clk and an active-low reset named rst_n in scope
`ifndef LAGGED_RISE_TOGGLE_DETECTOR_DEFINES_SVH
`define LAGGED_RISE_TOGGLE_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrt check failed");

// next-cycle implication, disabled during reset
`define LRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrt check failed");

// next-cycle implication that also runs through reset
`define LRT_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lrt check failed");

`endif

### rtl/lrt_pkg.sv
// package for the lagged rise toggle detector
// sizes, register codes and shared types; no dependencies
package lrt_pkg;

  localparam int MAX_LAG    = 1024;
  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int LAG_W      = $clog2(MAX_LAG + 1);
  localparam int CFG_LAG_W  = 11;
  localparam int LAGX_W     = (LAG_W > CFG_LAG_W) ? LAG_W : CFG_LAG_W;
  localparam int SINCE_W    = $clog2(4 * MAX_LAG);
  localparam int SINCE_MAX  = 4 * MAX_LAG - 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG       = 2'd1;

  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST = 16'sd16000;
  localparam logic [CFG_LAG_W-1:0]       LAG_RST       = 11'd100;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] threshold;
    logic [LAG_W-1:0]           lag;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              have;
  } acc_t;

endpackage

### rtl/lrt_in_if.sv
// input sample channel of the detector
// depends on lrt_pkg
interface lrt_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [lrt_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/lrt_out_if.sv
// result channel of the detector
// no dependencies
interface lrt_out_if;
  logic valid;
  logic ready;
  logic level;
  logic toggled;

  modport source (output valid, output level, output toggled, input ready);
  modport sink   (input valid, input level, input toggled, output ready);
endinterface

### rtl/lrt_cfg_if.sv
// register write channel of the detector
// depends on lrt_pkg
interface lrt_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lrt_pkg::CFG_IDX_W-1:0]    index;
  logic [lrt_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/lrt_ram.sv
// generic single-write, single-read ram with registered read (old data on collision)
// no dependencies
module lrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### rtl/lrt_cfg.sv
// configuration registers: threshold and lag, lag clamped to the line depth
// depends on lrt_pkg and lrt_cfg_if
module lrt_cfg (
  input  logic            clk,
  input  logic            rst_n,
  lrt_cfg_if.sink         cfg,
  output lrt_pkg::cfg_t   cfg_o
);

  logic signed [lrt_pkg::SAMPLE_W-1:0] threshold_r;
  logic [lrt_pkg::CFG_LAG_W-1:0]       lag_r;
  logic [lrt_pkg::LAGX_W-1:0]          lag_x;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= lrt_pkg::THRESHOLD_RST;
      lag_r       <= lrt_pkg::LAG_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        lrt_pkg::REG_THRESHOLD: threshold_r <= cfg.data[lrt_pkg::SAMPLE_W-1:0];
        lrt_pkg::REG_LAG:       lag_r       <= cfg.data[lrt_pkg::CFG_LAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lag_x           = lrt_pkg::LAGX_W'(lag_r);
    cfg_o.threshold = threshold_r;
    if (lag_x > lrt_pkg::LAGX_W'(lrt_pkg::MAX_LAG)) begin
      cfg_o.lag = lrt_pkg::LAG_W'(lrt_pkg::MAX_LAG);
    end else begin
      cfg_o.lag = lag_x[lrt_pkg::LAG_W-1:0];
    end
  end

endmodule

### rtl/lrt_addr.sv
// write pointer, fill count and lagged read address of the delay line
// depends on lrt_pkg
module lrt_addr (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  lrt_pkg::cfg_t cfg_i,
  output lrt_pkg::acc_t acc_o
);

  logic [lrt_pkg::ADDR_W-1:0] wp_r, wp_nxt;
  logic [lrt_pkg::LAG_W-1:0]  fill_r, fill_nxt;
  logic [lrt_pkg::LAG_W-1:0]  wp_x;
  logic [lrt_pkg::LAG_W-1:0]  ra_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    wp_x     = lrt_pkg::LAG_W'(wp_r);
    if (accept) begin
      if (wp_x == lrt_pkg::LAG_W'(lrt_pkg::MAX_LAG - 1)) begin
        wp_nxt = '0;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
      if (fill_r < lrt_pkg::LAG_W'(lrt_pkg::MAX_LAG)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (wp_x >= cfg_i.lag) begin
      ra_x = wp_x - cfg_i.lag;
    end else begin
      ra_x = wp_x + lrt_pkg::LAG_W'(lrt_pkg::MAX_LAG) - cfg_i.lag;
    end
    acc_o.waddr = wp_r;
    acc_o.raddr = ra_x[lrt_pkg::ADDR_W-1:0];
    acc_o.have  = (cfg_i.lag != '0) && (fill_r >= cfg_i.lag);
  end

endmodule

### rtl/lrt_decide.sv
// crossing test, holdoff counter, output level and result register
// depends on lrt_pkg and lrt_out_if
module lrt_decide (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrt_pkg::cfg_t                       cfg_i,
  input  logic                                accept,
  input  logic signed [lrt_pkg::SAMPLE_W-1:0] sample,
  input  logic                                have,
  input  logic [lrt_pkg::SAMPLE_W-1:0]        lagged,
  output logic                                in_ready,
  lrt_out_if.source                           out
);

  logic                                s1_valid_r, s1_valid_nxt;
  logic signed [lrt_pkg::SAMPLE_W-1:0] cur_r;
  logic                                have_r;
  logic [lrt_pkg::SINCE_W-1:0]         since_r, since_nxt, since_inc, holdoff;
  logic                                level_r, level_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_level_r, out_toggled_r;
  logic                                advance, flip;

  assign advance  = s1_valid_r && (!out_valid_r || out.ready);
  assign in_ready = !s1_valid_r || advance;

  assign out.valid   = out_valid_r;
  assign out.level   = out_level_r;
  assign out.toggled = out_toggled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      since_r     <= lrt_pkg::SINCE_W'(lrt_pkg::SINCE_MAX);
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      since_r     <= since_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r  <= sample;
      have_r <= have;
    end
    if (advance) begin
      out_level_r   <= level_nxt;
      out_toggled_r <= flip;
    end
  end

  always_comb begin
    if (since_r < lrt_pkg::SINCE_W'(lrt_pkg::SINCE_MAX)) begin
      since_inc = since_r + 1'b1;
    end else begin
      since_inc = since_r;
    end
    holdoff = lrt_pkg::SINCE_W'(cfg_i.lag) << 1;
    flip = have_r && (since_inc > holdoff) && ($signed(lagged) < cfg_i.threshold)
           && (cur_r >= cfg_i.threshold);

    since_nxt = since_r;
    level_nxt = level_r;
    if (advance) begin
      since_nxt = flip ? '0 : since_inc;
      level_nxt = level_r ^ flip;
    end

    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

### rtl/lagged_rise_toggle_detector.sv
// top level of the lagged rise toggle detector
// depends on lrt_pkg, the channel interfaces, lrt_cfg, lrt_addr, lrt_ram, lrt_decide
//
//  channel  | dir | payload            | handshake
//  in_ch    | in  | sample (s16)       | valid/ready
//  out_ch   | out | level, toggled     | valid/ready
//  cfg_ch   | in  | index (2), data 16 | valid/ready, always ready
//
// one word per cycle sustained while out_ch is ready; each word does one delay-line read and one write
// in the same cycle, and the compare and holdoff update use the registered sample and read data
// from input accept a word passes the crossing stage registers, then the output register, to result valid
// reset clears pointer, fill count, holdoff (to satisfied) and level; no ram clear
// a stalled result holds one word in the crossing stage, then input ready drops
module lagged_rise_toggle_detector (
  input  logic     clk,
  input  logic     rst_n,
  lrt_in_if.sink   in_ch,
  lrt_out_if.source out_ch,
  lrt_cfg_if.sink  cfg_ch
);

  lrt_pkg::cfg_t                cfg;
  lrt_pkg::acc_t                acc;
  logic                         in_ready;
  logic                         accept;
  logic [lrt_pkg::SAMPLE_W-1:0] lagged;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  lrt_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .cfg_o (cfg)
  );

  lrt_addr u_addr (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cfg_i  (cfg),
    .acc_o  (acc)
  );

  lrt_ram #(
    .WIDTH (lrt_pkg::SAMPLE_W),
    .DEPTH (lrt_pkg::MAX_LAG)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (acc.waddr),
    .wdata (in_ch.sample),
    .re    (accept),
    .raddr (acc.raddr),
    .rdata (lagged)
  );

  lrt_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_i    (cfg),
    .accept   (accept),
    .sample   (in_ch.sample),
    .have     (acc.have),
    .lagged   (lagged),
    .in_ready (in_ready),
    .out      (out_ch)
  );

endmodule

### rtl/lrt_checker.sv
// port-level checks for the lagged rise toggle detector, bound to the top level
// depends on lagged_rise_toggle_detector_defines.svh
`include "lagged_rise_toggle_detector_defines.svh"

module lrt_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_level,
  input logic out_toggled
);

  logic last_level_r;
  logic last_toggled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r   <= 1'b0;
      last_toggled_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_level_r   <= out_level;
      last_toggled_r <= out_toggled;
    end
  end

  // level moves only with a toggle flag
  `LRT_ASSERT_NOW(a_level_follows_flag, out_valid, out_level == (last_level_r ^ out_toggled))
  // holdoff forbids flips on two words in a row
  `LRT_ASSERT_NOW(a_no_double_flip, out_valid && out_toggled, !last_toggled_r)
  // a stalled word holds
  `LRT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                   out_valid && $stable(out_level) && $stable(out_toggled))
  // no word straight out of reset
  `LRT_ASSERT_NEXT_ANY(a_reset_empty, !rst_n, !out_valid)

endmodule

bind lagged_rise_toggle_detector lrt_checker u_lrt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_level   (out_ch.level),
  .out_toggled (out_ch.toggled)
);
